[design/lcr_pkg.sv]
// Shared types and constants for the longest consecutive run block.
package lcr_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned OUT_LEN_W = 11;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [OUT_LEN_W-1:0] LEN_SAT = 11'd2047;

	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		logic shift;
		logic clr;
	} cell_ctl_t;

endpackage

[design/longest_consecutive_run_top.sv]
// Top level: chain of table cells and the insert / run-search sequencer.
// An insert runs through S_INS_W and S_INS_D: match, decide, shift.
// A final word runs a scan of CAPACITY steps; each step looks at the tail entry, checks for a predecessor
// and, for a run head, walks the run member by member. Words are taken only in S_IDLE, after an
// insert or scan ends; a waiting result stalls only the end of the next scan.
// Reset: arst_n clears all valid bits, counts, flags and the result register at once.
module longest_consecutive_run_top #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // number[31:0]
	input  logic [0:0]  s_axis_tuser,  // has_number[0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // longest_length[10:0], overflowed[11], zero[15:12]
);
	import lcr_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = $clog2(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE, S_INS_W, S_INS_D, S_SCAN, S_PRED_W, S_PRED_D, S_SUCC_W, S_SUCC_D
	} state_t;

	state_t st_q;
	val_t num_q, query_q, cur_q;
	logic fin_q, ovf_q, m_valid_q, m_ovf_q;
	logic [CW-1:0] cnt_q, len_q, best_q;
	logic [SW-1:0] scan_q;
	logic [OUT_LEN_W-1:0] m_len_q;

	val_t cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_vld, cell_hit;
	cell_ctl_t ctl;
	val_t head_val;
	logic head_vld;
	logic hit_any, ins_do, adv, last_step;
	logic run_adv, end_wait, emit;
	val_t tail_val;
	logic tail_vld;
	logic [31:0] best_w;
	logic [OUT_LEN_W-1:0] best_sat;

	assign tail_val = cell_val[CAPACITY-1];
	assign tail_vld = cell_vld[CAPACITY-1];
	assign hit_any = |cell_hit;
	assign ins_do = (st_q == S_INS_D) && !hit_any && (cnt_q != CW'(CAPACITY));
	assign run_adv = ((st_q == S_SCAN) && !tail_vld)
		|| ((st_q == S_PRED_D) && hit_any)
		|| ((st_q == S_SUCC_D) && !(hit_any && (cur_q != VAL_MAX)));
	assign last_step = (scan_q == SW'(CAPACITY - 1));
	assign end_wait = run_adv && last_step && m_valid_q && !m_axis_tready;
	assign adv = run_adv && !end_wait;
	assign emit = adv && last_step;
	assign head_val = ins_do ? num_q : tail_val;
	assign head_vld = ins_do ? 1'b1 : tail_vld;
	assign ctl.shift = ins_do || adv;
	assign ctl.clr = emit;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			lcr_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev_val ((gi == 0) ? head_val : cell_val[(gi == 0) ? 0 : gi-1]),
				.prev_vld ((gi == 0) ? head_vld : cell_vld[(gi == 0) ? 0 : gi-1]),
				.query    (query_q),
				.val      (cell_val[gi]),
				.vld      (cell_vld[gi]),
				.hit      (cell_hit[gi])
			);
		end
	endgenerate

	assign best_w = 32'(best_q);
	assign best_sat = (best_w > 32'(LEN_SAT)) ? LEN_SAT : best_w[OUT_LEN_W-1:0];

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {4'b0000, m_ovf_q, m_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_len_q <= '0;
			m_ovf_q <= 1'b0;
			best_q <= '0;
			scan_q <= '0;
			fin_q <= 1'b0;
		end else begin
			m_valid_q <= emit || (m_valid_q && !m_axis_tready);
			if (adv) begin
				if (last_step) begin
					m_len_q <= (st_q == S_SUCC_D && len_q > best_q) ?
						((32'(len_q) > 32'(LEN_SAT)) ? LEN_SAT : len_q[OUT_LEN_W-1:0]) : best_sat;
					m_ovf_q <= ovf_q;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					best_q <= '0;
					scan_q <= '0;
					st_q <= S_IDLE;
				end else begin
					if (st_q == S_SUCC_D && len_q > best_q) begin
						best_q <= len_q;
					end
					scan_q <= scan_q + 1'b1;
					st_q <= S_SCAN;
				end
			end else if (!end_wait) begin
				case (st_q)
					S_IDLE: begin
						if (s_axis_tvalid && s_axis_tready) begin
							num_q <= s_axis_tdata;
							query_q <= s_axis_tdata;
							fin_q <= s_axis_tlast;
							if (s_axis_tuser[0]) begin
								st_q <= S_INS_W;
							end else if (s_axis_tlast) begin
								st_q <= S_SCAN;
							end
						end
					end
					S_INS_W: st_q <= S_INS_D;
					S_INS_D: begin
						if (ins_do) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (!hit_any) begin
							ovf_q <= 1'b1;
						end
						st_q <= fin_q ? S_SCAN : S_IDLE;
					end
					S_SCAN: begin
						if (tail_val == VAL_MIN) begin
							cur_q <= tail_val;
							len_q <= CW'(1);
							query_q <= tail_val + 1'b1;
							st_q <= S_SUCC_W;
						end else begin
							query_q <= tail_val - 1'b1;
							st_q <= S_PRED_W;
						end
					end
					S_PRED_W: st_q <= S_PRED_D;
					S_PRED_D: begin
						cur_q <= tail_val;
						len_q <= CW'(1);
						query_q <= tail_val + 1'b1;
						st_q <= S_SUCC_W;
					end
					S_SUCC_W: st_q <= S_SUCC_D;
					S_SUCC_D: begin
						cur_q <= cur_q + 1'b1;
						len_q <= len_q + 1'b1;
						query_q <= cur_q + 32'd2;
						st_q <= S_SUCC_W;
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY)) else $error("distinct count above capacity");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CW'(CAPACITY))) else $error("overflow with free entries");
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_hit)) else $error("duplicate value stored");
	a_clear_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> (cnt_q == '0) && !ovf_q && (cell_vld == '0))
		else $error("table not cleared after answer");

endmodule

[design/lcr_cell.sv]
// One table cell: holds a value and its valid bit, shifts to its neighbor, flags a query match.
module lcr_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  lcr_pkg::cell_ctl_t ctl,
	input  lcr_pkg::val_t    prev_val,
	input  logic             prev_vld,
	input  lcr_pkg::val_t    query,
	output lcr_pkg::val_t    val,
	output logic             vld,
	output logic             hit
);
	import lcr_pkg::*;

	val_t val_q;
	logic vld_q;
	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= vld_q && (val_q == query);
			if (ctl.clr) begin
				vld_q <= 1'b0;
			end else if (ctl.shift) begin
				vld_q <= prev_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= prev_val;
		end
	end

	assign val = val_q;
	assign vld = vld_q;
	assign hit = hit_q;

endmodule

[tb/sv/longest_consecutive_run_top_tb.sv]
// Testbench for the longest consecutive run block: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

import lcr_pkg::*;

class run_scoreboard;
	localparam int unsigned CAP = 1024;
	bit members[val_t];
	bit table_full;
	logic [11:0] answers_due[$];
	int errors;
	int answers;
	int overflow_answers;

	function void note_input(val_t number, bit has_number, bit final_item);
		int unsigned best;
		int unsigned len;
		val_t v;
		if (has_number && !members.exists(number)) begin
			if (members.num() >= CAP)
				table_full = 1;
			else
				members[number] = 1;
		end
		if (!final_item)
			return;
		best = 0;
		foreach (members[key]) begin
			if (key != VAL_MIN && members.exists(key - 1))
				continue;
			v = key;
			len = 1;
			while (v != VAL_MAX && members.exists(v + 1)) begin
				v = v + 1;
				len++;
			end
			if (len > best)
				best = len;
		end
		if (best > LEN_SAT)
			best = LEN_SAT;
		answers_due.push_back({table_full, best[10:0]});
		members.delete();
		table_full = 0;
	endfunction

	function void check_result(logic [15:0] word);
		logic [11:0] due;
		answers++;
		if (answers_due.size() == 0) begin
			$display("%0t: unexpected result %h", $time, word);
			errors++;
			return;
		end
		due = answers_due.pop_front();
		if (due[11])
			overflow_answers++;
		if (word[10:0] !== due[10:0]) begin
			$display("%0t: longest_length expected %0d actual %0d", $time, due[10:0], word[10:0]);
			errors++;
		end
		if (word[11] !== due[11]) begin
			$display("%0t: overflowed expected %0d actual %0d", $time, due[11], word[11]);
			errors++;
		end
		if (word[15:12] !== 4'b0) begin
			$display("%0t: pad bits expected 0 actual %h", $time, word[15:12]);
			errors++;
		end
	endfunction

	function int pending();
		return answers_due.size();
	endfunction
endclass

module longest_consecutive_run_top_tb;
	localparam int unsigned CAP = 1024;
	localparam int unsigned CYCLE_LIMIT = 40000000;
	localparam int unsigned TAIL = 3 * CAP + 2 * CAP + 100;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	run_scoreboard sb;
	int unsigned cycles;
	int unsigned words_sent;
	int unsigned burst_left;
	bit long_hold_done;

	longest_consecutive_run_top #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	initial begin
		int unsigned hold;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && sb.answers >= 2) begin
				long_hold_done = 1;
				m_axis_tready <= 1'b0;
				repeat (20000) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				hold = $urandom_range(1, 40);
				repeat (hold) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(val_t number, bit has_number, bit final_item);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= number;
		s_axis_tuser <= has_number;
		s_axis_tlast <= final_item;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(number, has_number, final_item);
		if (has_number || final_item)
			words_sent++;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_random_set();
		int unsigned size;
		val_t base;
		val_t number;
		bit has_number;
		size = $urandom_range(1, 25);
		case ($urandom_range(0, 3))
			0: base = $urandom;
			1: base = VAL_MIN + $urandom_range(0, 6);
			2: base = VAL_MAX - $urandom_range(0, 30);
			default: base = -$urandom_range(0, 20);
		endcase
		for (int unsigned i = 0; i < size; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_word($urandom, 1'b0, 1'b0);
			number = ($urandom_range(0, 9) == 0) ? val_t'($urandom)
				: base + $urandom_range(0, 30);
			has_number = (i + 1 < size) || ($urandom_range(0, 3) != 0);
			send_word(number, has_number, i + 1 == size);
		end
	endtask

	task automatic send_overflow_set();
		val_t base;
		base = $urandom;
		for (int unsigned i = 0; i < CAP + 12; i++) begin
			send_word(base + i, 1'b1, 1'b0);
			if (i % 100 == 0)
				send_word(base + i, 1'b1, 1'b0);
		end
		send_word(base, 1'b1, 1'b1);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		words_sent = 0;
		burst_left = 0;
		long_hold_done = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word('0, 1'b0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(VAL_MIN, 1'b1, 1'b0);
		send_word(VAL_MIN + 1, 1'b1, 1'b1);
		send_word(VAL_MAX - 1, 1'b1, 1'b0);
		send_word(VAL_MAX, 1'b1, 1'b0);
		send_word(VAL_MIN, 1'b1, 1'b0);
		send_word('0, 1'b0, 1'b1);
		send_word(32'd5, 1'b1, 1'b0);
		send_word(32'd5, 1'b1, 1'b0);
		send_word(32'd6, 1'b1, 1'b0);
		send_word(32'd7, 1'b1, 1'b1);
		send_word('0, 1'b1, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_word(32'd1, 1'b1, 1'b0);
		send_word('0, 1'b1, 1'b0);
		send_word(32'hAAAA_5555, 1'b1, 1'b0);
		send_word(32'h5555_AAAA, 1'b1, 1'b1);

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		send_overflow_set();
		while (words_sent < 1750)
			send_random_set();
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		$display("Covered %0d words, %0d answers, %0d with table overflow.",
			words_sent, sb.answers, sb.overflow_answers);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
